### hw/rtl/rv32_pkg.sv
// Package for the RV32I executor: opcodes, halt causes, phases, result record.
// No dependencies.
package rv32_pkg;

   localparam logic [6:0] MAJ_REG    = 7'h33;
   localparam logic [6:0] MAJ_IMM    = 7'h13;
   localparam logic [6:0] MAJ_LOAD   = 7'h03;
   localparam logic [6:0] MAJ_STORE  = 7'h23;
   localparam logic [6:0] MAJ_LUI    = 7'h37;
   localparam logic [6:0] MAJ_AUIPC  = 7'h17;
   localparam logic [6:0] MAJ_JAL    = 7'h6F;
   localparam logic [6:0] MAJ_JALR   = 7'h67;
   localparam logic [6:0] MAJ_BRANCH = 7'h63;
   localparam logic [6:0] MAJ_SYSTEM = 7'h73;

   localparam logic [1:0] CAUSE_NONE     = 2'd0;
   localparam logic [1:0] CAUSE_ECALL    = 2'd1;
   localparam logic [1:0] CAUSE_ILLEGAL  = 2'd2;
   localparam logic [1:0] CAUSE_MISALIGN = 2'd3;

   localparam logic [31:0] PC_RESET = 32'h0040_0000;
   localparam logic [31:0] HALT_CODE_RESET = 32'd10;

   localparam logic [4:0] REG_A0 = 5'd10;

   localparam int DMEM_WORDS = 4096;
   localparam int DMEM_AW = $clog2(DMEM_WORDS);

   localparam logic KIND_EXEC    = 1'b0;
   localparam logic KIND_PRELOAD = 1'b1;

   typedef enum logic [1:0] {
      PH_ACCEPT   = 2'd0,
      PH_OPERANDS = 2'd1,
      PH_EXECUTE  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic [1:0]  halt_cause;
      logic        reg_written;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        mem_written;
      logic [31:0] mem_address;
      logic [31:0] mem_value;
   } result_type;

endpackage

### hw/rtl/rv32i_instruction_executor_core.sv
// RV32I executor top level: decode, register file, data memory, write-back.
// Depends on rv32_pkg, rv32_regfile, rv32_dmem.
// Result valid and write-back come at the same edge, at the end of the execute phase.
// A new transaction is taken only in the accept phase, when the output can take it,
// as register file and memory serve one instruction at a time (read-modify-write).
// Reset: synchronous; pc 0x00400000, running, halt code 10, register valid bits clear.
module rv32i_instruction_executor_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,  // instruction, preload_address, preload_data
   input  logic         req_tuser,  // kind: execute or preload
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,  // next_pc, halt_cause, reg_written, reg_index,
                                    // reg_value, mem_written, mem_address, mem_value
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data
);
   import rv32_pkg::*;

   localparam int AW = DMEM_AW;

   // phase: accept, operands arrive, memory data arrives and execute
   phase_type   phase_ff, phase_in;
   logic [31:0] pc_ff, pc_in;
   logic [1:0]  stop_ff, stop_in;
   logic [31:0] hcode_ff;
   logic        kind_ff;
   logic [31:0] ins_ff, paddr_ff, pdata_ff;
   logic [31:0] rs1_ff, rs2_ff, addr_ff;
   logic        out_valid_ff;
   result_type  out_ff, res;

   logic [31:0] rfa, rfb, dmem_q;
   logic        rf_we;
   logic [31:0] rs1v, rs2v;
   logic [4:0]  ra_sel;

   assign req_tready = (phase_ff == PH_ACCEPT) && (!out_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;
   wire acc = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) hcode_ff <= HALT_CODE_RESET;
      else if (csr_valid && csr_ready) hcode_ff <= csr_data;
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         kind_ff  <= req_tuser;
         ins_ff   <= req_tdata[31:0];
         paddr_ff <= req_tdata[63:32];
         pdata_ff <= req_tdata[95:64];
      end
   end

   // port A rereads a0 during the operand phase for ecall
   logic [4:0] rf_a_addr, rf_b_addr;
   always_comb begin
      rf_a_addr = ins_ff[19:15];
      rf_b_addr = ins_ff[24:20];
      if (acc) begin
         rf_a_addr = req_tdata[19:15];
         rf_b_addr = req_tdata[24:20];
      end else if (phase_ff == PH_OPERANDS) begin
         rf_a_addr = REG_A0;
      end
   end
   assign ra_sel = rf_a_addr;

   logic [4:0] a_addr_q, b_addr_q;
   always_ff @(posedge clock) begin
      a_addr_q <= ra_sel;
      b_addr_q <= rf_b_addr;
   end

   logic [31:0] valid_ff;
   assign rs1v = (a_addr_q == 5'd0 || !valid_ff[a_addr_q]) ? 32'd0 : rfa;
   assign rs2v = (b_addr_q == 5'd0 || !valid_ff[b_addr_q]) ? 32'd0 : rfb;

   logic [31:0] ins, immi, imms, ea_p1;
   assign ins  = ins_ff;
   assign immi = {{20{ins[31]}}, ins[31:20]};
   assign imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
   assign ea_p1 = rs1v + ((ins[6:0] == MAJ_STORE) ? imms : immi);

   always_ff @(posedge clock) begin
      if (phase_ff == PH_OPERANDS) begin
         rs1_ff  <= rs1v;
         rs2_ff  <= rs2v;
         addr_ff <= ea_p1;
      end
   end

   logic [AW-1:0] dm_rd, dm_wa;
   logic          dm_we;
   logic [31:0]   dm_wd;
   assign dm_rd = addr_ff[AW+1:2];

   rv32_regfile u_rf (
      .clock(clock), .rd_addr_a(rf_a_addr), .rd_addr_b(rf_b_addr),
      .rd_data_a(rfa), .rd_data_b(rfb),
      .wr_en(rf_we), .wr_addr(res.reg_index), .wr_data(res.reg_value)
   );

   logic [AW-1:0] dm_rd_addr;
   assign dm_rd_addr = (phase_ff == PH_OPERANDS) ? ea_p1[AW+1:2] : dm_rd;

   rv32_dmem #(.AW(AW)) u_dm (
      .clock(clock), .rd_addr(dm_rd_addr), .rd_data(dmem_q),
      .wr_en(dm_we), .wr_addr(dm_wa), .wr_data(dm_wd)
   );

   // execute in the last phase
   logic [31:0] a, b, alu, w, mval, npc, immb, immj;
   logic [6:0]  op, f7;
   logic [2:0]  f3;
   logic [4:0]  shamt, off;
   logic        take;
   logic [1:0]  cause;
   logic        wreg, wmem;
   logic [31:0] rval;

   always_comb begin
      op = ins[6:0];
      f3 = ins[14:12];
      f7 = ins[31:25];
      a  = rs1_ff;
      b  = (op == MAJ_REG) ? rs2_ff : immi;
      immb = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
      immj = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
      shamt = b[4:0];
      off = {addr_ff[1:0], 3'b000};
      case (f3)
         3'd0: alu = (op == MAJ_REG && f7[5]) ? a - b : a + b;
         3'd1: alu = a << shamt;
         3'd2: alu = {31'd0, $signed(a) < $signed(b)};
         3'd3: alu = {31'd0, a < b};
         3'd4: alu = a ^ b;
         3'd5: alu = (f7 != 7'd0) ? 32'($signed(a) >>> shamt) : a >> shamt;
         3'd6: alu = a | b;
         default: alu = a & b;
      endcase
      w = dmem_q >> off;
      npc = pc_ff + 32'd4;
      cause = CAUSE_NONE;
      wreg = 1'b0;
      wmem = 1'b0;
      rval = 32'd0;
      mval = 32'd0;
      take = 1'b0;
      case (op)
         MAJ_REG: begin
            wreg = 1'b1;
            rval = alu;
            if (f7 != 7'd0 && !(f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5)))
               cause = CAUSE_ILLEGAL;
         end
         MAJ_IMM: begin
            wreg = 1'b1;
            rval = alu;
            if (f3 == 3'd1 && f7 != 7'd0) cause = CAUSE_ILLEGAL;
            if (f3 == 3'd5 && f7 != 7'd0 && f7 != 7'h20) cause = CAUSE_ILLEGAL;
         end
         MAJ_LOAD: begin
            wreg = 1'b1;
            case (f3)
               3'd0: rval = {{24{w[7]}}, w[7:0]};
               3'd1: rval = {{16{w[15]}}, w[15:0]};
               3'd2: rval = dmem_q;
               3'd4: rval = {24'd0, w[7:0]};
               3'd5: rval = {16'd0, w[15:0]};
               default: cause = CAUSE_ILLEGAL;
            endcase
         end
         MAJ_STORE: begin
            wmem = 1'b1;
            case (f3)
               3'd0: mval = (dmem_q & ~(32'hFF << off)) | ((rs2_ff & 32'hFF) << off);
               3'd1: mval = (dmem_q & ~(32'hFFFF << off)) | ((rs2_ff & 32'hFFFF) << off);
               3'd2: mval = rs2_ff;
               default: cause = CAUSE_ILLEGAL;
            endcase
         end
         MAJ_LUI:   begin wreg = 1'b1; rval = {ins[31:12], 12'd0}; end
         MAJ_AUIPC: begin wreg = 1'b1; rval = pc_ff + {ins[31:12], 12'd0}; end
         MAJ_JAL: begin
            wreg = 1'b1;
            rval = pc_ff + 32'd4;
            npc = pc_ff + immj;
            if (npc[1:0] != 2'd0) cause = CAUSE_MISALIGN;
         end
         MAJ_JALR: begin
            wreg = 1'b1;
            rval = pc_ff + 32'd4;
            npc = (rs1_ff + immi) & 32'hFFFF_FFFE;
            if (f3 != 3'd0) cause = CAUSE_ILLEGAL;
            else if (npc[1:0] != 2'd0) cause = CAUSE_MISALIGN;
         end
         MAJ_BRANCH: begin
            case (f3)
               3'd0: take = rs1_ff == rs2_ff;
               3'd1: take = rs1_ff != rs2_ff;
               3'd4: take = $signed(rs1_ff) < $signed(rs2_ff);
               3'd5: take = $signed(rs1_ff) >= $signed(rs2_ff);
               3'd6: take = rs1_ff < rs2_ff;
               3'd7: take = rs1_ff >= rs2_ff;
               default: cause = CAUSE_ILLEGAL;
            endcase
            if (take) begin
               npc = pc_ff + immb;
               if (npc[1:0] != 2'd0) cause = CAUSE_MISALIGN;
            end
         end
         MAJ_SYSTEM: begin
            if (ins[31:7] != 25'd0) cause = CAUSE_ILLEGAL;
            else if (rs1v == hcode_ff) cause = CAUSE_ECALL;
         end
         default: cause = CAUSE_ILLEGAL;
      endcase

      res = '0;
      res.next_pc = pc_ff;
      res.halt_cause = stop_ff;
      if (kind_ff == KIND_EXEC && stop_ff == CAUSE_NONE) begin
         if (cause != CAUSE_NONE) begin
            res.halt_cause = cause;
         end else begin
            res.next_pc = npc;
            if (wreg && ins[11:7] != 5'd0) begin
               res.reg_written = 1'b1;
               res.reg_index = ins[11:7];
               res.reg_value = rval;
            end
            if (wmem) begin
               res.mem_written = 1'b1;
               res.mem_address = {addr_ff[31:2], 2'b00};
               res.mem_value = mval;
            end
         end
      end
   end

   wire fin = (phase_ff == PH_EXECUTE);
   assign rf_we = fin && res.reg_written;
   assign dm_we = fin && (kind_ff == KIND_PRELOAD || res.mem_written);
   assign dm_wa = (kind_ff == KIND_PRELOAD) ? paddr_ff[AW+1:2] : addr_ff[AW+1:2];
   assign dm_wd = (kind_ff == KIND_PRELOAD) ? pdata_ff : mval;

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_ACCEPT: if (acc) phase_in = PH_OPERANDS;
         PH_OPERANDS: phase_in = PH_EXECUTE;
         default: phase_in = PH_ACCEPT;
      endcase
   end

   assign pc_in = fin ? res.next_pc : pc_ff;
   assign stop_in = fin ? res.halt_cause : stop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ACCEPT;
         pc_ff <= PC_RESET;
         stop_ff <= CAUSE_NONE;
         out_valid_ff <= 1'b0;
         valid_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         pc_ff <= pc_in;
         stop_ff <= stop_in;
         if (rf_we) valid_ff[res.reg_index] <= 1'b1;
         if (fin) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin) out_ff <= res;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {7'd0, out_ff.mem_value, out_ff.mem_address, out_ff.mem_written,
                       out_ff.reg_value, out_ff.reg_index, out_ff.reg_written,
                       out_ff.halt_cause, out_ff.next_pc};

   assert property (@(posedge clock) disable iff (reset) acc |=> phase_ff == PH_OPERANDS)
      else $error("phase did not advance");
   assert property (@(posedge clock) disable iff (reset) fin |=> rsp_tvalid)
      else $error("result lost");
   assert property (@(posedge clock) disable iff (reset) stop_ff != CAUSE_NONE |-> !rf_we)
      else $error("write while halted");
endmodule

### hw/rtl/rv32_regfile.sv
// 32 x 32 register file, synchronous memory, registered reads, two read ports.
// Depends on nothing.
module rv32_regfile (
   input  logic        clock,
   input  logic [4:0]  rd_addr_a,
   input  logic [4:0]  rd_addr_b,
   output logic [31:0] rd_data_a,
   output logic [31:0] rd_data_b,
   input  logic        wr_en,
   input  logic [4:0]  wr_addr,
   input  logic [31:0] wr_data
);
   logic [31:0] mem [32];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule

### hw/rtl/rv32_dmem.sv
// Data memory, synchronous, one read and one write port, registered read.
// Depends on nothing.
module rv32_dmem #(
   parameter int AW = 12
) (
   input  logic          clock,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data
);
   logic [31:0] mem [2**AW];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
